### sv/spike_regularity_monitor_defines.svh
// assertion macros for the spike regularity monitor
// no dependencies
`ifndef SPIKE_REGULARITY_MONITOR_DEFINES_SVH
`define SPIKE_REGULARITY_MONITOR_DEFINES_SVH
`define SRM_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("violated");
`define SRM_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("violated");
`endif

### sv/srm_pkg.sv
// shared types and constants for the spike regularity monitor
// no dependencies
package srm_pkg;
	localparam int IntervalCount = 5;
	localparam int IdxW = $clog2(IntervalCount + 1);
	localparam int SumW = 32 + $clog2(IntervalCount + 1);

	localparam logic [1:0] CFG_UPPER = 2'd0;
	localparam logic [1:0] CFG_LOWER = 2'd1;
	localparam logic [1:0] CFG_VLIM  = 2'd2;

	typedef struct packed {
		logic signed [15:0] sample_v;
		logic [31:0]        time_stamp;
	} in_item_t;

	typedef struct packed {
		logic        spike_seen;
		logic        decision_done;
		logic        raise_conductance;
		logic [31:0] regularity_cv;
	} out_item_t;

	// front to back queue entry
	typedef struct packed {
		logic        spike;
		logic        eval;
		logic [31:0] ts;
	} job_t;
endpackage

### sv/srm_front.sv
// front end: hysteresis spike detection and job queue
// depends on srm_pkg
module srm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  srm_pkg::in_item_t in_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic signed [15:0] thr_up,
	input  logic signed [15:0] thr_lo,
	output srm_pkg::job_t    job,
	output logic             job_valid,
	input  logic             job_take
);
	import srm_pkg::*;

	logic            armed_q;
	logic [IdxW-1:0] cnt_q;
	job_t            q_q [2];
	logic [1:0]      wp_q, rp_q;
	logic            push, spk;
	logic [1:0]      fill;

	assign fill = wp_q - rp_q;
	assign in_stall = fill[1];
	assign push = in_valid && !in_stall;
	assign spk = armed_q && (in_data.sample_v >= thr_up);
	assign job_valid = fill != 2'd0;
	assign job = q_q[rp_q[0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b1;
			cnt_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) begin
				if (spk) begin
					armed_q <= 1'b0;
					cnt_q <= (cnt_q == IdxW'(IntervalCount)) ? '0 : cnt_q + 1'b1;
				end else if (!armed_q && in_data.sample_v <= thr_lo) begin
					armed_q <= 1'b1;
				end
				wp_q <= wp_q + 1'b1;
			end
			if (job_take && job_valid) rp_q <= rp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q[0]].spike <= spk;
			q_q[wp_q[0]].eval <= spk && (cnt_q == IdxW'(IntervalCount));
			q_q[wp_q[0]].ts <= in_data.time_stamp;
		end
	end
endmodule

### sv/srm_back.sv
// back end: interval store, iterative variance, root and division
// depends on srm_pkg and the defines header
`include "spike_regularity_monitor_defines.svh"
module srm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  srm_pkg::job_t     job,
	input  logic              job_valid,
	output logic              job_take,
	input  logic [31:0]       vlim,
	output srm_pkg::out_item_t out_data,
	output logic              out_valid,
	input  logic              out_stall
);
	import srm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MEAN = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_VDIV = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_CDIV = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam int AccW = 64 + $clog2(IntervalCount + 1);

	logic [2:0]      st_q;
	logic [IdxW-1:0] idx_q;
	logic [31:0]     prev_q;
	logic [31:0]     ivs_q [IntervalCount];
	logic [SumW-1:0] sum_q;
	logic [31:0]     cv_q;
	logic [6:0]      step_q;
	logic [AccW-1:0] acc_q;
	logic [AccW-1:0] qe_q;
	logic [31:0]     mean_q;
	logic [63:0]     var_q;
	logic [63:0]     rx_q;
	logic [33:0]     rrem_q;
	logic [31:0]     root_q;
	logic [47:0]     num_q;
	logic [32:0]     drem_q;
	logic [47:0]     cq_q;
	logic            ospk_q, odone_q, oraise_q, ovld_q;
	logic [31:0]     iv, dlt;
	logic [63:0]     sq;
	logic [$clog2(IntervalCount)-1:0] sel;
	logic [AccW-1:0] r5;
	logic [AccW-1:0] d5_next;
	logic            d5_done;
	logic [35:0]     rtry;
	logic [32:0]     dr;
	logic            out_free;
	logic            out_load;

	assign out_free = !ovld_q || !out_stall;
	assign job_take = (st_q == ST_IDLE) && job_valid && out_free;
	assign out_load = (job_take && !(job.spike && job.eval)) || (st_q == ST_OUT && out_free);
	assign iv = job.ts - prev_q;
	assign sel = step_q[$clog2(IntervalCount)-1:0];
	assign dlt = (ivs_q[sel] >= mean_q) ? ivs_q[sel] - mean_q : mean_q - ivs_q[sel];
	assign sq = {32'd0, dlt} * {32'd0, dlt};
	assign r5 = acc_q - (qe_q << 2) - qe_q;
	assign rtry = {rrem_q, rx_q[63:62]} - {2'b00, root_q, 2'b01};
	assign dr = {drem_q[31:0], num_q[47]};

	// reciprocal of five by shift and add, then step up until the remainder is below five
	always_comb begin
		d5_next = qe_q;
		d5_done = 1'b0;
		case (step_q)
			7'd0: d5_next = (acc_q >> 1) + (acc_q >> 2);
			7'd1: d5_next = qe_q + (qe_q >> 4);
			7'd2: d5_next = qe_q + (qe_q >> 8);
			7'd3: d5_next = qe_q + (qe_q >> 16);
			7'd4: d5_next = qe_q + (qe_q >> 32);
			7'd5: d5_next = qe_q + (qe_q >> 64);
			7'd6: d5_next = qe_q >> 2;
			default: begin
				if (r5 >= AccW'(IntervalCount)) d5_next = qe_q + 1'b1;
				else d5_done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			sum_q <= '0;
			cv_q <= '0;
			ovld_q <= 1'b0;
			ospk_q <= 1'b0;
			odone_q <= 1'b0;
			oraise_q <= 1'b0;
			prev_q <= '0;
			ivs_q <= '{default: '0};
			step_q <= '0;
			acc_q <= '0;
			qe_q <= '0;
			mean_q <= '0;
			var_q <= '0;
			rx_q <= '0;
			rrem_q <= '0;
			root_q <= '0;
			num_q <= '0;
			drem_q <= '0;
			cq_q <= '0;
		end else begin
			if (out_load) ovld_q <= 1'b1;
			else if (ovld_q && !out_stall) ovld_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (job_take) begin
						if (!job.spike) begin
							ospk_q <= 1'b0; odone_q <= 1'b0; oraise_q <= 1'b0;
						end else begin
							prev_q <= job.ts;
							if (idx_q != '0) begin
								ivs_q[idx_q - 1'b1] <= iv;
								sum_q <= sum_q + SumW'(iv);
							end
							if (job.eval) begin
								acc_q <= AccW'(sum_q + SumW'(iv));
								step_q <= '0;
								st_q <= ST_MEAN;
								idx_q <= '0;
							end else begin
								idx_q <= idx_q + 1'b1;
								ospk_q <= 1'b1; odone_q <= 1'b0; oraise_q <= 1'b0;
							end
						end
					end
				end
				ST_MEAN: begin
					qe_q <= d5_next;
					step_q <= step_q + 1'b1;
					if (d5_done) begin
						mean_q <= 32'(qe_q);
						step_q <= '0;
						acc_q <= '0;
						sum_q <= '0;
						st_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					acc_q <= acc_q + AccW'(sq);
					step_q <= step_q + 1'b1;
					if (step_q == 7'(IntervalCount - 1)) begin
						step_q <= '0;
						st_q <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					qe_q <= d5_next;
					step_q <= step_q + 1'b1;
					if (d5_done) begin
						var_q <= 64'(qe_q);
						rx_q <= 64'(qe_q);
						rrem_q <= '0;
						root_q <= '0;
						step_q <= '0;
						st_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					// two bits of radicand per step
					rx_q <= rx_q << 2;
					if (!rtry[35]) begin
						rrem_q <= rtry[33:0];
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rrem_q <= {rrem_q[31:0], rx_q[63:62]};
						root_q <= {root_q[30:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 7'd31) begin
						num_q <= {(!rtry[35]) ? {root_q[30:0], 1'b1} : {root_q[30:0], 1'b0},
							16'd0};
						drem_q <= '0;
						step_q <= '0;
						st_q <= ST_CDIV;
					end
				end
				ST_CDIV: begin
					num_q <= num_q << 1;
					if (dr >= {1'b0, mean_q}) begin
						drem_q <= dr - {1'b0, mean_q};
						cq_q <= {cq_q[46:0], 1'b1};
					end else begin
						drem_q <= dr;
						cq_q <= {cq_q[46:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 7'd47) st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (mean_q == '0 || cq_q[47:32] != '0) cv_q <= '1;
						else cv_q <= cq_q[31:0];
						ospk_q <= 1'b1; odone_q <= 1'b1;
						oraise_q <= var_q > {32'd0, vlim};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ovld_q;
	assign out_data.spike_seen = ospk_q;
	assign out_data.decision_done = odone_q;
	assign out_data.raise_conductance = oraise_q;
	assign out_data.regularity_cv = cv_q;

	`SRM_ASSERT_IMP(a_raise_done, clk, arst_n, out_valid && out_data.raise_conductance, out_data.decision_done)
	`SRM_ASSERT_IMP(a_done_spk, clk, arst_n, out_valid && out_data.decision_done, out_data.spike_seen)
	`SRM_ASSERT_NEXT(a_take_idle, clk, arst_n, job_take && !job.eval, st_q == ST_IDLE)
endmodule

### sv/spike_regularity_monitor.sv
// Spike regularity monitor: one result per sample.
// Input transfer to result transfer, unstalled: the front queue, then the output register;
// an evaluating spike adds two reciprocal divisions by five, 32-step root, 48-step cv division.
// One sample per cycle outside evaluations while out_stall is low; a two-entry queue lets the
// front take samples while the back end evaluates.
// Reset (arst_n, asynchronous): detector armed, counts and cv cleared, registers defaulted.
module spike_regularity_monitor (
	input  logic               clk,
	input  logic               arst_n,
	input  srm_pkg::in_item_t  in_data,
	input  logic               in_valid,
	output logic               in_stall,
	output srm_pkg::out_item_t out_data,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import srm_pkg::*;

	logic signed [15:0] up_q, lo_q;
	logic [31:0]        vlim_q;
	job_t               job;
	logic               job_valid, job_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= '0;
			lo_q <= '0;
			vlim_q <= 32'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UPPER: up_q <= cfg_data[15:0];
				CFG_LOWER: lo_q <= cfg_data[15:0];
				CFG_VLIM:  vlim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	srm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .in_valid(in_valid),
		.in_stall(in_stall), .thr_up(up_q), .thr_lo(lo_q), .job(job),
		.job_valid(job_valid), .job_take(job_take)
	);

	srm_back u_back (
		.clk(clk), .arst_n(arst_n), .job(job), .job_valid(job_valid),
		.job_take(job_take), .vlim(vlim_q), .out_data(out_data),
		.out_valid(out_valid), .out_stall(out_stall)
	);
endmodule
